@@ rtl/gcpe_pkg.sv @@
// Shared types, constants and helpers of the glyph column pixel expander.
`default_nettype none
package gcpe_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned CalcW      = COORD_BITS + 2;
  localparam int unsigned DimW       = 11;
  localparam int unsigned ColorW     = 16;
  localparam int unsigned SizeW      = 5;
  localparam int unsigned CountW     = 6;

  localparam logic [CalcW-1:0] CoordMax  = CalcW'((1 << COORD_BITS) - 1);
  localparam logic [CalcW-1:0] CoordSpan = CalcW'(1 << COORD_BITS);

  localparam logic [ColorW-1:0] ForeReset   = 16'hFFE0;
  localparam logic [ColorW-1:0] BackReset   = 16'hF81F;
  localparam logic [DimW-1:0]   WidthReset  = 11'd480;
  localparam logic [DimW-1:0]   HeightReset = 11'd800;

  localparam logic [SizeW-1:0] Size12 = 5'd12;
  localparam logic [SizeW-1:0] Size16 = 5'd16;
  localparam logic [SizeW-1:0] Size24 = 5'd24;

  typedef enum logic [1:0] {
    CFG_FORE_COLOR    = 2'd0,
    CFG_BG_COLOR      = 2'd1,
    CFG_SCREEN_WIDTH  = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                  first_byte;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [SizeW-1:0]      glyph_size;
    logic                  transparent;
    logic [7:0]            glyph_bits;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ColorW-1:0]     pixel_color;
    logic                  last;
  } out_word_t;

  typedef struct packed {
    logic [ColorW-1:0] fore_color;
    logic [ColorW-1:0] bg_color;
    logic [DimW-1:0]   screen_width;
    logic [DimW-1:0]   screen_height;
  } cfg_t;

  // One column run: start pixel, per-row color select and rows to write.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [7:0]            fore_sel;
    logic [7:0]            mask;
  } job_t;

  function automatic logic [CountW-1:0] glyph_bytes(logic [SizeW-1:0] size);
    logic [CountW-1:0] n;
    n = '0;
    if (size == Size12) n = 6'd12;
    if (size == Size16) n = 6'd16;
    if (size == Size24) n = 6'd36;
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/glyph_column_pixel_expander.sv @@
// A byte's first pixel word passes the run queue, run register and output register.
// A byte yields 0 to 8 pixel words; the back end emits one pixel word per cycle
// while the output is not stalled. Bytes that yield no pixel are never queued.
// The front end takes a byte every cycle while the run queue has room.
// Reset: queue and output empty, no character active, registers at their defaults.
`default_nettype none
module glyph_column_pixel_expander #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gcpe_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output gcpe_pkg::out_word_t      out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  gcpe_pkg::cfg_t cfg_q;
  gcpe_pkg::job_t job_in, job_out;
  logic           q_push, q_full, q_pop, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fore_color    <= gcpe_pkg::ForeReset;
      cfg_q.bg_color      <= gcpe_pkg::BackReset;
      cfg_q.screen_width  <= gcpe_pkg::WidthReset;
      cfg_q.screen_height <= gcpe_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      unique case (gcpe_pkg::cfg_idx_e'(cfg_index_i))
        gcpe_pkg::CFG_FORE_COLOR:    cfg_q.fore_color    <= cfg_data_i;
        gcpe_pkg::CFG_BG_COLOR:      cfg_q.bg_color      <= cfg_data_i;
        gcpe_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[gcpe_pkg::DimW-1:0];
        gcpe_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[gcpe_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  gcpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .full_i     (q_full),
    .push_o     (q_push),
    .job_o      (job_in)
  );

  gcpe_fifo #(
    .WIDTH ($bits(gcpe_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  gcpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .pop_o       (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("run queue overflow");

  a_push_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (job_in.mask != '0)) else $error("empty run queued");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("run queue underflow");
`endif

endmodule
`default_nettype wire

@@ rtl/gcpe_fifo.sv @@
// Small flip-flop queue between the byte front end and the pixel back end.
`default_nettype none
module gcpe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/gcpe_front.sv @@
// Front end: tracks the cursor and turns each glyph byte that draws into a column run.
`default_nettype none
module gcpe_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gcpe_pkg::in_word_t in_word_i,
  input  wire gcpe_pkg::cfg_t    cfg_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output gcpe_pkg::job_t         job_o
);

  localparam int unsigned CW = gcpe_pkg::COORD_BITS;
  localparam int unsigned KW = gcpe_pkg::CalcW;

  logic [CW-1:0]                x_q, x_d;
  logic [CW-1:0]                y_q, y_d;
  logic [CW-1:0]                top_q, top_d;
  logic [gcpe_pkg::SizeW-1:0]   fh_q, fh_d;
  logic                         skip_q, skip_d;
  logic                         halted_q, halted_d;
  logic [gcpe_pkg::CountW-1:0]  cnt_q, cnt_d;

  logic                         accept;
  logic [CW-1:0]                eff_x, eff_y, eff_top;
  logic [gcpe_pkg::SizeW-1:0]   eff_fh;
  logic                         eff_skip, eff_halted;
  logic [gcpe_pkg::CountW-1:0]  eff_cnt, cnt_next, glyph_len;
  logic [KW-1:0]                lim, y_plus1, rows_to_edge, rows_to_col, x_plus1;
  logic                         row_halt, col_end, col_halt, mid_halt;
  logic [3:0]                   run_len;
  logic [7:0]                   mask, fore_sel;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    if (in_word_i.first_byte) begin
      eff_x      = in_word_i.origin_x;
      eff_y      = in_word_i.origin_y;
      eff_top    = in_word_i.origin_y;
      eff_fh     = in_word_i.glyph_size;
      eff_skip   = in_word_i.transparent;
      eff_cnt    = '0;
      eff_halted = (gcpe_pkg::glyph_bytes(in_word_i.glyph_size) == '0);
    end else begin
      eff_x      = x_q;
      eff_y      = y_q;
      eff_top    = top_q;
      eff_fh     = fh_q;
      eff_skip   = skip_q;
      eff_cnt    = cnt_q;
      eff_halted = halted_q;
    end
  end

  // Rows left before the screen edge and before the column fills.
  always_comb begin
    lim = KW'(cfg_i.screen_height);
    if (lim > gcpe_pkg::CoordSpan) begin
      lim = gcpe_pkg::CoordSpan;
    end
    y_plus1      = KW'(eff_y) + KW'(1);
    rows_to_edge = (lim > y_plus1) ? lim - y_plus1 : '0;
    rows_to_col  = KW'(eff_top) + KW'(eff_fh) - y_plus1;
    row_halt     = (rows_to_edge <= rows_to_col) && (rows_to_edge < KW'(8));
    col_end      = !row_halt && (rows_to_col < KW'(8));
    x_plus1      = KW'(eff_x) + KW'(1);
    col_halt     = col_end && ((x_plus1 >= KW'(cfg_i.screen_width)) ||
                               (x_plus1 > gcpe_pkg::CoordMax));
    mid_halt     = row_halt || col_halt;
    if (row_halt) begin
      run_len = rows_to_edge[3:0] + 4'd1;
    end else if (col_end) begin
      run_len = rows_to_col[3:0] + 4'd1;
    end else begin
      run_len = 4'd8;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      fore_sel[b] = in_word_i.glyph_bits[7-b];
      mask[b]     = (4'(b) < run_len) && (in_word_i.glyph_bits[7-b] || !eff_skip);
    end
  end

  assign glyph_len = gcpe_pkg::glyph_bytes(eff_fh);
  assign cnt_next  = eff_cnt + gcpe_pkg::CountW'(1);

  always_comb begin
    x_d      = eff_x;
    y_d      = eff_y;
    top_d    = eff_top;
    fh_d     = eff_fh;
    skip_d   = eff_skip;
    halted_d = eff_halted;
    cnt_d    = eff_cnt;
    if (!eff_halted) begin
      if (col_end) begin
        y_d = eff_top;
        if (!col_halt) begin
          x_d = x_plus1[CW-1:0];
        end
      end else if (!row_halt) begin
        y_d = eff_y + CW'(8);
      end
      if (mid_halt) begin
        halted_d = 1'b1;
      end else begin
        cnt_d    = cnt_next;
        halted_d = (cnt_next >= glyph_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      top_q    <= '0;
      fh_q     <= '0;
      skip_q   <= 1'b0;
      halted_q <= 1'b1;
      cnt_q    <= '0;
    end else if (accept) begin
      x_q      <= x_d;
      y_q      <= y_d;
      top_q    <= top_d;
      fh_q     <= fh_d;
      skip_q   <= skip_d;
      halted_q <= halted_d;
      cnt_q    <= cnt_d;
    end
  end

  // Drop bytes that draw nothing.
  assign push_o         = accept && !eff_halted && (mask != '0);
  assign job_o.x        = eff_x;
  assign job_o.y        = eff_y;
  assign job_o.fore_sel = fore_sel;
  assign job_o.mask     = mask;

endmodule
`default_nettype wire

@@ rtl/gcpe_back.sv @@
// Back end: walks a column run, one pixel word per unstalled cycle.
`default_nettype none
module gcpe_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                job_valid_i,
  input  wire gcpe_pkg::job_t      job_i,
  output logic                     pop_o,
  input  wire gcpe_pkg::cfg_t      cfg_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output gcpe_pkg::out_word_t      out_word_o
);

  localparam int unsigned CW = gcpe_pkg::COORD_BITS;

  gcpe_pkg::job_t      work_q, work_d;
  logic                work_vld_q, work_vld_d;
  gcpe_pkg::out_word_t out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic [2:0] idx;
  logic [7:0] rest;
  logic       advance, done;

  always_comb begin
    idx = '0;
    for (int b = 7; b >= 0; b--) begin
      if (work_q.mask[b]) begin
        idx = 3'(b);
      end
    end
  end

  assign rest    = work_q.mask & ~(8'd1 << idx);
  assign advance = work_vld_q && (!out_vld_q || out_ready_i);
  assign done    = advance && (rest == '0);
  assign pop_o   = job_valid_i && (!work_vld_q || done);

  always_comb begin
    work_d     = work_q;
    work_vld_d = work_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    if (advance) begin
      out_d.pixel_x     = work_q.x;
      out_d.pixel_y     = work_q.y + CW'(idx);
      out_d.pixel_color = work_q.fore_sel[idx] ? cfg_i.fore_color : cfg_i.bg_color;
      out_d.last        = (rest == '0);
      out_vld_d         = 1'b1;
      work_d.mask       = rest;
      if (done) begin
        work_vld_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    // Refill the run register when empty or as the run finishes.
    if (pop_o) begin
      work_d     = job_i;
      work_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      work_vld_q <= work_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

@@ dv/glyph_column_pixel_expander_tb.sv @@
// Self-checking testbench: glyph byte streams in, pixel words checked.
`timescale 1ns / 1ps
module glyph_column_pixel_expander_tb;

  localparam int CoordTop    = (1 << gcpe_pkg::COORD_BITS) - 1;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;
  localparam int ShownErrors = 10;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  gcpe_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  gcpe_pkg::out_word_t out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [15:0]         cfg_data_i  = '0;

  glyph_column_pixel_expander dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register copies and glyph state of the pixel predictor.
  logic [gcpe_pkg::ColorW-1:0]     pen_fore    = gcpe_pkg::ForeReset;
  logic [gcpe_pkg::ColorW-1:0]     pen_back    = gcpe_pkg::BackReset;
  logic [gcpe_pkg::DimW-1:0]       scr_w       = gcpe_pkg::WidthReset;
  logic [gcpe_pkg::DimW-1:0]       scr_h       = gcpe_pkg::HeightReset;
  logic [gcpe_pkg::COORD_BITS-1:0] col_x       = '0;
  logic [gcpe_pkg::COORD_BITS-1:0] row_y       = '0;
  logic [gcpe_pkg::COORD_BITS-1:0] top_y       = '0;
  logic [gcpe_pkg::SizeW-1:0]      font_h      = '0;
  logic                            skip_clear  = 1'b0;
  logic                            stopped     = 1'b1;
  logic [gcpe_pkg::CountW-1:0]     bytes_taken = '0;

  gcpe_pkg::in_word_t  glyph_stream[$];
  gcpe_pkg::out_word_t pixels_due[$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned words_seen   = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;

  function automatic int bytes_per_glyph(logic [gcpe_pkg::SizeW-1:0] size);
    case (size)
      gcpe_pkg::Size12: return 12;
      gcpe_pkg::Size16: return 16;
      gcpe_pkg::Size24: return 36;
      default:          return 0;
    endcase
  endfunction

  // Expand one accepted glyph byte into the pixel words it must produce.
  task automatic expand_byte(gcpe_pkg::in_word_t w);
    logic [gcpe_pkg::COORD_BITS+1:0] next_row;
    logic [gcpe_pkg::COORD_BITS+1:0] next_col;
    logic [7:0]                      bits;
    gcpe_pkg::out_word_t             run[8];
    int                              drawn;
    drawn = 0;
    if (w.first_byte) begin
      col_x       = w.origin_x;
      row_y       = w.origin_y;
      top_y       = w.origin_y;
      font_h      = w.glyph_size;
      skip_clear  = w.transparent;
      bytes_taken = '0;
      stopped     = (bytes_per_glyph(w.glyph_size) == 0);
    end
    if (!stopped) begin
      bits = w.glyph_bits;
      for (int b = 0; b < 8; b++) begin
        if (bits[7] || !skip_clear) begin
          run[drawn].pixel_x     = col_x;
          run[drawn].pixel_y     = row_y;
          run[drawn].pixel_color = bits[7] ? pen_fore : pen_back;
          run[drawn].last        = 1'b0;
          drawn++;
        end
        bits     = bits << 1;
        next_row = {2'b00, row_y} + 1'b1;
        if (next_row >= scr_h || next_row > CoordTop) begin
          stopped = 1'b1;
          break;
        end
        row_y = next_row[gcpe_pkg::COORD_BITS-1:0];
        // full column: back to the top row, drop the rest of the byte
        if ({2'b00, row_y} - {2'b00, top_y} == font_h) begin
          row_y    = top_y;
          next_col = {2'b00, col_x} + 1'b1;
          if (next_col >= scr_w || next_col > CoordTop) stopped = 1'b1;
          else col_x = next_col[gcpe_pkg::COORD_BITS-1:0];
          break;
        end
      end
      if (!stopped) begin
        bytes_taken = bytes_taken + 1'b1;
        if (bytes_taken >= bytes_per_glyph(font_h)) stopped = 1'b1;
      end
      if (drawn > 0) run[drawn-1].last = 1'b1;
      for (int k = 0; k < drawn; k++) pixels_due.push_back(run[k]);
    end
  endtask

  task automatic note_error(string why, logic have_want, gcpe_pkg::out_word_t want,
                            gcpe_pkg::out_word_t got);
    errors++;
    if (errors <= ShownErrors) begin
      if (have_want)
        $display("%s: expected x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
                 why, want.pixel_x, want.pixel_y, want.pixel_color, want.last,
                 got.pixel_x, got.pixel_y, got.pixel_color, got.last);
      else
        $display("%s: got x=%0d y=%0d color=%h last=%b",
                 why, got.pixel_x, got.pixel_y, got.pixel_color, got.last);
    end
  endtask

  // Input driver: bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expand_byte(in_word_i);
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (glyph_stream.size() > 0) begin
          in_word_i  <= glyph_stream.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each pixel word with the oldest expected one.
  always @(posedge clk_i) begin : watch_pixels
    gcpe_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (pixels_due.size() == 0) begin
        note_error("unexpected pixel word", 1'b0, '0, out_word_o);
      end else begin
        want = pixels_due.pop_front();
        if (out_word_o.pixel_x !== want.pixel_x || out_word_o.pixel_y !== want.pixel_y ||
            out_word_o.pixel_color !== want.pixel_color || out_word_o.last !== want.last)
          note_error("pixel word mismatch", 1'b1, want, out_word_o);
      end
    end
  end

  // Output ready: changing stall patterns plus a few long hold-offs.
  int          hold_left  = 0;
  int          mode_left  = 0;
  int unsigned hold_at    = 40;
  int unsigned ready_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (words_seen >= hold_at) begin
      // hold long enough for the run queue to back up into the input
      hold_left = $urandom_range(150, 250);
      hold_at   = hold_at + 300;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(8, 64);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("glyph_column_pixel_expander_tb NOT OK");
      $finish;
    end
  end

  task automatic push_word(gcpe_pkg::in_word_t w);
    glyph_stream.push_back(w);
    words_queued++;
  endtask

  task automatic push_head(int x, int y, int size, logic transp, logic [7:0] bits);
    gcpe_pkg::in_word_t w;
    w.first_byte  = 1'b1;
    w.origin_x    = gcpe_pkg::COORD_BITS'(x);
    w.origin_y    = gcpe_pkg::COORD_BITS'(y);
    w.glyph_size  = gcpe_pkg::SizeW'(size);
    w.transparent = transp;
    w.glyph_bits  = bits;
    push_word(w);
  endtask

  // Continuation byte; the fields latched on a first byte carry noise.
  task automatic push_body(logic [7:0] bits);
    gcpe_pkg::in_word_t w;
    w.first_byte  = 1'b0;
    w.origin_x    = gcpe_pkg::COORD_BITS'($urandom_range(0, CoordTop));
    w.origin_y    = gcpe_pkg::COORD_BITS'($urandom_range(0, CoordTop));
    w.glyph_size  = gcpe_pkg::SizeW'($urandom_range(0, 31));
    w.transparent = 1'($urandom_range(0, 1));
    w.glyph_bits  = bits;
    push_word(w);
  endtask

  function automatic logic [7:0] rand_bits();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (words_taken != words_queued || pixels_due.size() != 0) @(posedge clk_i);
    // extra idle time; bytes that draw nothing never enter the run queue
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(gcpe_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gcpe_pkg::CFG_FORE_COLOR:   pen_fore = data;
      gcpe_pkg::CFG_BG_COLOR:     pen_back = data;
      gcpe_pkg::CFG_SCREEN_WIDTH: scr_w    = data[gcpe_pkg::DimW-1:0];
      default:                    scr_h    = data[gcpe_pkg::DimW-1:0];
    endcase
  endtask

  task automatic set_screen(logic [15:0] fore, logic [15:0] back, int w, int h);
    write_reg(gcpe_pkg::CFG_FORE_COLOR, fore);
    write_reg(gcpe_pkg::CFG_BG_COLOR, back);
    write_reg(gcpe_pkg::CFG_SCREEN_WIDTH, 16'(w));
    write_reg(gcpe_pkg::CFG_SCREEN_HEIGHT, 16'(h));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed glyphs with random content; some cut short, some
  // overlong, some with a bad size, and a little pure noise.
  task automatic random_glyphs(int target);
    int                 counted;
    int                 size;
    int                 len;
    int                 nbytes;
    int                 x;
    int                 y;
    gcpe_pkg::in_word_t w;
    counted = 0;
    while (counted < target) begin
      case ($urandom_range(0, 9))
        0: begin
          w.first_byte  = 1'($urandom_range(0, 1));
          w.origin_x    = gcpe_pkg::COORD_BITS'($urandom_range(0, CoordTop));
          w.origin_y    = gcpe_pkg::COORD_BITS'($urandom_range(0, CoordTop));
          w.glyph_size  = gcpe_pkg::SizeW'($urandom_range(0, 31));
          w.transparent = 1'($urandom_range(0, 1));
          w.glyph_bits  = 8'($urandom);
          push_word(w);
        end
        1: begin
          do size = $urandom_range(0, 31);
          while (bytes_per_glyph(gcpe_pkg::SizeW'(size)) != 0);
          push_head($urandom_range(0, CoordTop), $urandom_range(0, CoordTop), size,
                    1'($urandom_range(0, 1)), rand_bits());
          repeat ($urandom_range(0, 3)) push_body(rand_bits());
        end
        default: begin
          case ($urandom_range(0, 4))
            0, 1:    size = 12;
            2, 3:    size = 16;
            default: size = 24;
          endcase
          len = bytes_per_glyph(gcpe_pkg::SizeW'(size));
          case ($urandom_range(0, 5))
            0:       nbytes = $urandom_range(1, len - 1);
            1:       nbytes = len + $urandom_range(1, 3);
            default: nbytes = len;
          endcase
          case ($urandom_range(0, 3))
            0: begin
              x = $urandom_range(0, CoordTop);
              y = $urandom_range(0, CoordTop);
            end
            1: begin
              // near the right or bottom edge so a limit cuts the glyph
              x = int'(scr_w) - int'($urandom_range(1, 3));
              y = int'(scr_h) - int'($urandom_range(1, size + 2));
            end
            default: begin
              x = (int'(scr_w) > 20) ? $urandom_range(0, int'(scr_w) - 20) : 0;
              y = (int'(scr_h) > 30) ? $urandom_range(0, int'(scr_h) - 30) : 0;
            end
          endcase
          if (x < 0) x = 0;
          if (y < 0) y = 0;
          if (x > CoordTop) x = CoordTop;
          if (y > CoordTop) y = CoordTop;
          push_head(x, y, size, 1'($urandom_range(0, 1)), rand_bits());
          for (int i = 1; i < nbytes; i++) push_body(rand_bits());
          counted += (nbytes < len) ? nbytes : len;
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stopped until the first byte of a character arrives.
    push_body(8'hFF);
    push_head(0, 0, gcpe_pkg::Size12, 1'b0, 8'hFF);
    push_body(8'h00);  // four rows left in the column, drop the rest
    push_body(8'hA5);
    // Origin right of the screen: draw until the column ends.
    push_head(CoordTop, 5, gcpe_pkg::Size16, 1'b1, 8'h00);
    push_body(8'hFF);
    push_body(8'hFF);
    push_head(10, 799, gcpe_pkg::Size24, 1'b0, 8'h80);  // bottom row of the screen
    push_body(8'hFF);
    push_head(3, 3, 0, 1'b0, 8'hFF);
    push_head(3, 3, 31, 1'b1, 8'hFF);
    push_body(8'h5A);
    wait_drained();

    set_screen(16'h0000, 16'hFFFF, 1, 1024);
    push_head(0, 1020, gcpe_pkg::Size24, 1'b0, 8'hFF);  // run off the last coordinate
    push_head(0, 0, gcpe_pkg::Size12, 1'b1, 8'h55);
    push_body(8'hF0);                                   // column full, width reached
    push_body(8'hFF);
    wait_drained();

    set_screen(16'hFFFF, 16'h0000, 1024, 1);
    push_head(5, 0, gcpe_pkg::Size12, 1'b0, 8'h80);
    push_head(CoordTop, 0, gcpe_pkg::Size16, 1'b0, 8'h7F);
    push_head(CoordTop, CoordTop, gcpe_pkg::Size16, 1'b1, 8'hFF);
    wait_drained();

    set_screen(16'($urandom), 16'($urandom), $urandom_range(1, 1024), $urandom_range(1, 1024));
    random_glyphs(20);
    wait_drained();

    set_screen(16'($urandom), 16'($urandom), $urandom_range(1, 40), $urandom_range(1, 48));
    random_glyphs(20);
    wait_drained();

    set_screen(16'hFFFF, 16'h0000, 1024, 1024);
    random_glyphs(20);
    wait_drained();

    if (errors == 0) begin
      $display("glyph_column_pixel_expander_tb OK");
    end else begin
      $display("glyph_column_pixel_expander_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gcpe_pkg.sv
rtl/gcpe_fifo.sv
rtl/gcpe_front.sv
rtl/gcpe_back.sv
rtl/glyph_column_pixel_expander.sv
dv/glyph_column_pixel_expander_tb.sv
